// File: sv/lte_pkg.sv
package lte_pkg;

   localparam int GRID_ROWS_DEF = 64;
   localparam int GRID_COLS_DEF = 64;

   localparam int OPCODE_W   = 3;
   localparam int COORD_W    = 6;
   localparam int STUCK_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int NBR_W      = 4;

   localparam logic [STUCK_W-1:0] STUCK_LIMIT_RESET = 8'd120;
   localparam logic [NBR_W-1:0]   BIRTH_COUNT       = 4'd3;
   localparam logic [NBR_W-1:0]   SURVIVE_COUNT     = 4'd2;

   localparam logic CSR_IDX_STUCK_LIMIT = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET   = 3'd0,
      OP_CLEAR = 3'd1,
      OP_STEP  = 3'd2,
      OP_READ  = 3'd3,
      OP_MARK  = 3'd4
   } opcode_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SET,
      S_READ,
      S_CLEAR,
      S_MARK,
      S_EVAL,
      S_COMMIT
   } state_type;

endpackage

// File: sv/life_automaton_torus_engine_core.sv
// toroidal life engine, B3/S23, one command word at a time
// command channel: a word is taken when start is high and busy is low;
// req_opcode selects set cell, clear all, step, read cell or mark loaded
// result channel: every command gives one result word, shown for exactly
// one cycle with rsp_strobe high; the receiver cannot stall it
// unused opcodes and out-of-grid addresses are answered straight from idle;
// set and read pass through their own state, clear and mark loaded walk all rows
// step: one pass over the rows evaluates and compares the next generation;
// a new generation takes a second pass of the same length that writes it
// rate is set by the single read port of the grid memory: one row a cycle
// both generations live in one memory, one row per word, prior over live
// reset: busy stays high while the grid is cleared
// stuck_limit sits at byte address 0 of the csr port, reset value 120
module life_automaton_torus_engine_core #(
   parameter int GRID_ROWS = lte_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = lte_pkg::GRID_COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lte_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [lte_pkg::COORD_W-1:0]     req_row,
   input  logic [lte_pkg::COORD_W-1:0]     req_col,
   output logic                            rsp_strobe,
   output logic                            rsp_cell_alive,
   output logic                            rsp_advanced,
   output logic                            rsp_stuck,
   output logic                            rsp_reseed_request,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lte_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lte_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lte_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   import lte_pkg::*;

   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int CNT_W  = $clog2(GRID_ROWS + 4);
   localparam int WORD_W = 2 * GRID_COLS;

   localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_ROW0     = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_EVAL     = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_LAST_ROW = CNT_W'(GRID_ROWS - 1);
   localparam logic [CNT_W-1:0] CNT_ROWS     = CNT_W'(GRID_ROWS);
   localparam logic [CNT_W-1:0] CNT_SHIFT    = CNT_W'(GRID_ROWS + 1);
   localparam logic [CNT_W-1:0] CNT_WRAP     = CNT_W'(GRID_ROWS + 2);
   localparam logic [CNT_W-1:0] CNT_END      = CNT_W'(GRID_ROWS + 3);
   localparam logic [ROW_W-1:0] LAST_ROW_ADR = ROW_W'(GRID_ROWS - 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [GRID_COLS-1:0]   live_top_ff, live_top_in;
   logic [GRID_COLS-1:0]   live_mid_ff, live_mid_in;
   logic [GRID_COLS-1:0]   live_bot_ff, live_bot_in;
   logic [GRID_COLS-1:0]   prior_mid_ff, prior_mid_in;
   logic [GRID_COLS-1:0]   prior_bot_ff, prior_bot_in;
   logic [GRID_COLS-1:0]   row0_ff, row0_in;
   logic                   diff_live_ff, diff_live_in;
   logic                   diff_prior_ff, diff_prior_in;
   logic [STUCK_W-1:0]     stuck_count_ff, stuck_count_in;
   logic [STUCK_W-1:0]     stuck_limit_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_cell_ff, rsp_cell_in;
   logic                   rsp_adv_ff, rsp_adv_in;
   logic                   rsp_stuck_ff, rsp_stuck_in;
   logic                   rsp_req_ff, rsp_req_in;

   logic                   we;
   logic [ROW_W-1:0]       waddr, raddr;
   logic [WORD_W-1:0]      wdata, rdata;
   logic [GRID_COLS-1:0]   rd_live, rd_prior, cand, set_mask;
   logic [CNT_W-1:0]       cnt_inc, cnt_m1, cnt_m4;
   logic [STUCK_W-1:0]     stuck_plus;
   logic                   req_inside, diff_live_now, diff_prior_now;
   logic                   pass_shift, pass_eval;
   logic                   csr_write;

   lte_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GRID_ROWS)
   ) u_grid (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   lte_next_row #(
      .GRID_COLS (GRID_COLS)
   ) u_next_row (
      .above    (live_top_ff),
      .center   (live_mid_ff),
      .below    (live_bot_ff),
      .next_row (cand)
   );

   assign rd_live  = rdata[GRID_COLS-1:0];
   assign rd_prior = rdata[WORD_W-1:GRID_COLS];
   assign cnt_inc  = cnt_ff + CNT_ONE;
   assign cnt_m1   = cnt_ff - CNT_ONE;
   assign cnt_m4   = cnt_ff - CNT_EVAL;
   assign stuck_plus = stuck_count_ff + STUCK_W'(1);

   assign req_inside = (int'(req_row) < GRID_ROWS) && (int'(req_col) < GRID_COLS);

   assign pass_shift = (cnt_ff >= CNT_ONE) && (cnt_ff <= CNT_SHIFT);
   assign pass_eval  = (cnt_ff >= CNT_EVAL);

   assign diff_live_now  = diff_live_ff | (cand != live_mid_ff);
   assign diff_prior_now = diff_prior_ff | (cand != prior_mid_ff);

   always_comb begin
      set_mask = '0;
      set_mask[col_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         cnt_ff         <= '0;
         stuck_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         stuck_count_ff <= stuck_count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      live_top_ff   <= live_top_in;
      live_mid_ff   <= live_mid_in;
      live_bot_ff   <= live_bot_in;
      prior_mid_ff  <= prior_mid_in;
      prior_bot_ff  <= prior_bot_in;
      row0_ff       <= row0_in;
      diff_live_ff  <= diff_live_in;
      diff_prior_ff <= diff_prior_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_adv_ff    <= rsp_adv_in;
      rsp_stuck_ff  <= rsp_stuck_in;
      rsp_req_ff    <= rsp_req_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      live_top_in    = live_top_ff;
      live_mid_in    = live_mid_ff;
      live_bot_in    = live_bot_ff;
      prior_mid_in   = prior_mid_ff;
      prior_bot_in   = prior_bot_ff;
      row0_in        = row0_ff;
      diff_live_in   = diff_live_ff;
      diff_prior_in  = diff_prior_ff;
      stuck_count_in = stuck_count_ff;
      rsp_strobe_in  = 1'b0;
      rsp_cell_in    = 1'b0;
      rsp_adv_in     = 1'b0;
      rsp_stuck_in   = 1'b0;
      rsp_req_in     = 1'b0;
      we             = 1'b0;
      waddr          = cnt_ff[ROW_W-1:0];
      wdata          = '0;
      raddr          = ROW_W'(req_row);

      unique case (state_ff)
         S_INIT: begin
            we = 1'b1;
            if (cnt_ff == CNT_LAST_ROW) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end

         S_IDLE: begin
            if (start) begin
               row_in = ROW_W'(req_row);
               col_in = COL_W'(req_col);
               cnt_in = '0;
               unique case (req_opcode)
                  OP_SET: begin
                     if (req_inside) begin
                        state_in = S_SET;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (req_inside) begin
                        state_in = S_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_MARK:  state_in = S_MARK;
                  OP_STEP: begin
                     state_in      = S_EVAL;
                     diff_live_in  = 1'b0;
                     diff_prior_in = 1'b0;
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end

         S_SET: begin
            we            = 1'b1;
            waddr         = row_ff;
            wdata         = rdata | {{GRID_COLS{1'b0}}, set_mask};
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         S_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_cell_in   = rd_live[col_ff];
            state_in      = S_IDLE;
         end

         S_CLEAR: begin
            we = 1'b1;
            if (cnt_ff == CNT_LAST_ROW) begin
               stuck_count_in = '0;
               rsp_strobe_in  = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cnt_in = cnt_inc;
            end
         end

         S_MARK: begin
            // read row n while row n-1 gets prior = live
            raddr = cnt_ff[ROW_W-1:0];
            we    = (cnt_ff != '0);
            waddr = cnt_m1[ROW_W-1:0];
            wdata = {rd_live, rd_live};
            if (cnt_ff == CNT_ROWS) begin
               stuck_count_in = '0;
               rsp_strobe_in  = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cnt_in = cnt_inc;
            end
         end

         S_EVAL, S_COMMIT: begin
            // rows stream in as last, 0, 1, .. last; row 0 is replayed at the wrap
            raddr = (cnt_ff == '0) ? LAST_ROW_ADR : cnt_m1[ROW_W-1:0];
            if (cnt_ff == CNT_ROW0) begin
               row0_in = rd_live;
            end
            if (pass_shift) begin
               live_top_in  = live_mid_ff;
               live_mid_in  = live_bot_ff;
               live_bot_in  = rd_live;
               prior_mid_in = prior_bot_ff;
               prior_bot_in = rd_prior;
            end else if (cnt_ff == CNT_WRAP) begin
               live_top_in  = live_mid_ff;
               live_mid_in  = live_bot_ff;
               live_bot_in  = row0_ff;
               prior_mid_in = prior_bot_ff;
            end

            if (state_ff == S_EVAL) begin
               if (pass_eval) begin
                  diff_live_in  = diff_live_now;
                  diff_prior_in = diff_prior_now;
               end
               if (cnt_ff == CNT_END) begin
                  cnt_in = '0;
                  if (!diff_live_now || !diff_prior_now) begin
                     rsp_strobe_in = 1'b1;
                     rsp_stuck_in  = 1'b1;
                     state_in      = S_IDLE;
                     if (stuck_plus >= stuck_limit_ff) begin
                        rsp_req_in     = 1'b1;
                        stuck_count_in = '0;
                     end else begin
                        stuck_count_in = stuck_plus;
                     end
                  end else begin
                     state_in = S_COMMIT;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end else begin
               we    = pass_eval;
               waddr = cnt_m4[ROW_W-1:0];
               wdata = {live_mid_ff, cand};
               if (cnt_ff == CNT_END) begin
                  cnt_in         = '0;
                  stuck_count_in = '0;
                  rsp_strobe_in  = 1'b1;
                  rsp_adv_in     = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
      endcase
   end

   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stuck_limit_ff <= STUCK_LIMIT_RESET;
      end else if (csr_write && (paddr[2] == CSR_IDX_STUCK_LIMIT)) begin
         stuck_limit_ff <= pwdata[STUCK_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_STUCK_LIMIT) ?
                   {{(CSR_DATA_W - STUCK_W){1'b0}}, stuck_limit_ff} : '0;
   assign pready = 1'b1;

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_cell_alive     = rsp_cell_ff;
   assign rsp_advanced       = rsp_adv_ff;
   assign rsp_stuck          = rsp_stuck_ff;
   assign rsp_reseed_request = rsp_req_ff;

endmodule

// File: sv/lte_ram.sv
module lte_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/lte_next_row.sv
module lte_next_row #(
   parameter int GRID_COLS = 64
) (
   input  logic [GRID_COLS-1:0] above,
   input  logic [GRID_COLS-1:0] center,
   input  logic [GRID_COLS-1:0] below,
   output logic [GRID_COLS-1:0] next_row
);

   import lte_pkg::*;

   for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
      localparam int CL = (c + GRID_COLS - 1) % GRID_COLS;
      localparam int CR = (c + 1) % GRID_COLS;

      logic [NBR_W-1:0] nbrs;

      assign nbrs = NBR_W'(above[CL]) + NBR_W'(above[c]) + NBR_W'(above[CR])
                  + NBR_W'(center[CL]) + NBR_W'(center[CR])
                  + NBR_W'(below[CL]) + NBR_W'(below[c]) + NBR_W'(below[CR]);

      assign next_row[c] = (nbrs == BIRTH_COUNT) || (center[c] && (nbrs == SURVIVE_COUNT));
   end

endmodule
